// File: rtl/core/gpe_pkg.sv
// Shared constants, types and helper functions of the GGA position extractor.
`timescale 1ns / 1ps

package gpe_pkg;

  // Default store capacities.
  localparam int unsigned LAT_CHARS_DEF = 9;
  localparam int unsigned LON_CHARS_DEF = 11;

  // Default texts loaded when a coordinate field opens: "0000.0000" and "00000.0000".
  localparam int unsigned LAT_DEF_LEN = 9;
  localparam int unsigned LON_DEF_LEN = 10;
  localparam int unsigned LAT_DOT_POS = 4;
  localparam int unsigned LON_DOT_POS = 5;

  // Action codes of an input word.
  localparam logic ACT_BYTE   = 1'b0;
  localparam logic ACT_REPORT = 1'b1;

  // Part codes of a result word.
  localparam logic PART_LAT = 1'b0;
  localparam logic PART_LON = 1'b1;

  // Characters.
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_N     = 8'h4E;
  localparam logic [7:0] CH_P     = 8'h50;

  // Line parsing.
  localparam logic [2:0] HDR_DONE  = 3'd6;
  localparam logic [3:0] FIELD_LAT = 4'd3;
  localparam logic [3:0] FIELD_LON = 4'd5;
  localparam logic [3:0] FIELD_FIX = 4'd7;
  localparam logic [3:0] FIELD_MAX = 4'd15;
  localparam logic [3:0] COUNT_MAX = 4'd15;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;      // capture the accepted input word
    logic take;       // run the parser on the captured byte
    logic rpt_start;  // rewind the report position
    logic rpt_emit;   // load the next report character into the output register
  } gpe_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic slot_free;  // output register is empty or being taken this cycle
    logic at_last;    // the character at the report position is the final one
  } gpe_sts_t;

  function automatic logic [7:0] lat_dflt_char(input int unsigned pos);
    return (pos == LAT_DOT_POS) ? CH_DOT : CH_ZERO;
  endfunction

  function automatic logic [7:0] lon_dflt_char(input int unsigned pos);
    return (pos == LON_DOT_POS) ? CH_DOT : CH_ZERO;
  endfunction

endpackage

// File: rtl/core/gpe_chan_if.sv
// Valid/ready channel interfaces for the input words and the result words.
`timescale 1ns / 1ps

interface gpe_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] rx_byte;

  modport source (output valid, output action, output rx_byte, input ready);
  modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

interface gpe_out_if;
  logic       valid;
  logic       ready;
  logic       part;
  logic [7:0] char_code;
  logic       fix_valid;
  logic       last;

  modport source (output valid, output part, output char_code, output fix_valid,
                  output last, input ready);
  modport sink   (input valid, input part, input char_code, input fix_valid,
                  input last, output ready);
endinterface

// File: rtl/core/gga_position_extractor.sv
// Top level of the GGA position extractor: controller plus datapath behind two channels.
`timescale 1ns / 1ps

// The block reads a GPS receiver's text one byte per input word (action 0) and keeps the
// latitude (field 3) and longitude (field 5) text of GPGGA/GNGGA lines, plus a fix flag
// taken from the first character of field 7; the checksum is not checked. An input word
// with action 1 asks for a report, which streams the stored latitude characters and then
// the longitude characters, one result word each, with last set on the final one. A byte
// is accepted in ST_IDLE and parsed in ST_TAKE, after which in_ch.ready rises again. A
// report holds 2 to LAT_CHARS + LON_CHARS characters: the single output register emits
// one character per cycle while the sink is ready, and no input word is accepted until
// the final character has been loaded into it. The next byte may be accepted while that
// final character still waits to be taken. No clearing pass is needed after reset; the
// stores read as their default zero text.

module gga_position_extractor #(
  parameter int unsigned LAT_CHARS = gpe_pkg::LAT_CHARS_DEF,
  parameter int unsigned LON_CHARS = gpe_pkg::LON_CHARS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  gpe_in_if.sink       in_ch,
  gpe_out_if.source    out_ch
);

  gpe_pkg::gpe_cmd_t cmd;
  gpe_pkg::gpe_sts_t sts;
  logic              in_ready;

  // The controller owns the input handshake and paces the report.
  gpe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (in_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  assign in_ch.ready = in_ready;

  // The datapath holds the parser, the two stores and the output register.
  gpe_datapath #(
    .LAT_CHARS (LAT_CHARS),
    .LON_CHARS (LON_CHARS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .rx_byte       (in_ch.rx_byte),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .out_part      (out_ch.part),
    .out_char_code (out_ch.char_code),
    .out_fix_valid (out_ch.fix_valid),
    .out_last      (out_ch.last)
  );

endmodule

// File: rtl/core/gpe_ctrl.sv
// Controller state machine: sequences byte parsing and report streaming.
`timescale 1ns / 1ps

module gpe_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_action,
  output logic              in_ready,
  input  gpe_pkg::gpe_sts_t sts,
  output gpe_pkg::gpe_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TAKE,
    ST_REPORT
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd           = '0;
    cmd.latch     = accept;
    cmd.rpt_start = accept && (in_action == gpe_pkg::ACT_REPORT);
    cmd.take      = (state_r == ST_TAKE);
    cmd.rpt_emit  = (state_r == ST_REPORT) && sts.slot_free;

    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_action == gpe_pkg::ACT_REPORT) ? ST_REPORT : ST_TAKE;
        end
      end
      ST_TAKE: begin
        state_nxt = ST_IDLE;
      end
      ST_REPORT: begin
        if (sts.slot_free && sts.at_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/core/gpe_datapath.sv
// Datapath: line parser, coordinate stores, report position and output register.
`timescale 1ns / 1ps

module gpe_datapath #(
  parameter int unsigned LAT_CHARS = gpe_pkg::LAT_CHARS_DEF,
  parameter int unsigned LON_CHARS = gpe_pkg::LON_CHARS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  gpe_pkg::gpe_cmd_t cmd,
  output gpe_pkg::gpe_sts_t sts,
  input  logic [7:0]        rx_byte,
  input  logic              out_ready,
  output logic              out_valid,
  output logic              out_part,
  output logic [7:0]        out_char_code,
  output logic              out_fix_valid,
  output logic              out_last
);

  localparam int unsigned MAX_CHARS = (LAT_CHARS > LON_CHARS) ? LAT_CHARS : LON_CHARS;
  localparam int unsigned LEN_W     = $clog2(MAX_CHARS + 1);
  localparam int unsigned LAT_IW    = $clog2(LAT_CHARS);
  localparam int unsigned LON_IW    = $clog2(LON_CHARS);

  // Parser state.
  logic [2:0]       lp_r, lp_nxt;
  logic             hm_r, hm_nxt;
  logic [3:0]       fn_r, fn_nxt;
  logic [3:0]       fc_r, fc_nxt;
  logic             fix_r, fix_nxt;
  logic [7:0]       byte_r;

  // Stores. While a default flag is set the store reads as its default text.
  logic [7:0]       lat_text_r [LAT_CHARS];
  logic [7:0]       lon_text_r [LON_CHARS];
  logic [LEN_W-1:0] lat_len_r, lat_len_nxt;
  logic [LEN_W-1:0] lon_len_r, lon_len_nxt;
  logic             lat_dflt_r, lat_dflt_nxt;
  logic             lon_dflt_r, lon_dflt_nxt;
  logic             lat_we, lon_we;
  logic [LAT_IW-1:0] lat_wa;
  logic [LON_IW-1:0] lon_wa;

  // Report position and output register.
  logic             part_r, part_nxt;
  logic [LEN_W-1:0] sub_r, sub_nxt;
  logic [LEN_W-1:0] sub_inc;
  logic             out_vld_r, out_vld_nxt;
  logic             out_part_r;
  logic [7:0]       out_char_r;
  logic             out_fix_r;
  logic             out_last_r;
  logic [7:0]       lat_rd, lon_rd, rd_char;

  logic             hdr_ok;

  // Parser.
  always_comb begin
    lp_nxt       = lp_r;
    hm_nxt       = hm_r;
    fn_nxt       = fn_r;
    fc_nxt       = fc_r;
    fix_nxt      = fix_r;
    lat_len_nxt  = lat_len_r;
    lon_len_nxt  = lon_len_r;
    lat_dflt_nxt = lat_dflt_r;
    lon_dflt_nxt = lon_dflt_r;
    lat_we       = 1'b0;
    lon_we       = 1'b0;
    lat_wa       = lat_len_r[LAT_IW-1:0];
    lon_wa       = lon_len_r[LON_IW-1:0];
    hdr_ok       = 1'b0;

    if (cmd.take) begin
      if (byte_r == gpe_pkg::CH_NL) begin
        lp_nxt = '0;
        hm_nxt = 1'b0;
        fn_nxt = 4'd1;
        fc_nxt = '0;
      end else begin
        if (lp_r < gpe_pkg::HDR_DONE) begin
          case (lp_r)
            3'd0: hm_nxt = 1'b1;
            3'd1: if (byte_r != gpe_pkg::CH_G) hm_nxt = 1'b0;
            3'd2: if (byte_r != gpe_pkg::CH_P && byte_r != gpe_pkg::CH_N) hm_nxt = 1'b0;
            3'd3: if (byte_r != gpe_pkg::CH_G) hm_nxt = 1'b0;
            3'd4: if (byte_r != gpe_pkg::CH_G) hm_nxt = 1'b0;
            default: if (byte_r != gpe_pkg::CH_A) hm_nxt = 1'b0;
          endcase
          lp_nxt = lp_r + 3'd1;
        end
        hdr_ok = hm_nxt && (lp_nxt == gpe_pkg::HDR_DONE);

        if (byte_r == gpe_pkg::CH_COMMA) begin
          // The comma opens the next field; the field number checked is the new one.
          if (fn_r < gpe_pkg::FIELD_MAX) begin
            fn_nxt = fn_r + 4'd1;
          end
          fc_nxt = '0;
          if (hdr_ok) begin
            if (fn_nxt == gpe_pkg::FIELD_LAT) begin
              lat_dflt_nxt = 1'b1;
              lat_len_nxt  = LEN_W'(gpe_pkg::LAT_DEF_LEN);
            end else if (fn_nxt == gpe_pkg::FIELD_LON) begin
              lon_dflt_nxt = 1'b1;
              lon_len_nxt  = LEN_W'(gpe_pkg::LON_DEF_LEN);
            end else if (fn_nxt == gpe_pkg::FIELD_FIX) begin
              fix_nxt = 1'b1;
            end
          end
        end else begin
          if (hdr_ok) begin
            if (fn_r == gpe_pkg::FIELD_LAT) begin
              if (fc_r == '0) begin
                // First character of the field starts the store anew.
                lat_dflt_nxt = 1'b0;
                lat_we       = 1'b1;
                lat_wa       = '0;
                lat_len_nxt  = LEN_W'(1);
              end else if (lat_len_r < LEN_W'(LAT_CHARS)) begin
                lat_we      = 1'b1;
                lat_len_nxt = lat_len_r + LEN_W'(1);
              end
            end else if (fn_r == gpe_pkg::FIELD_LON) begin
              if (fc_r == '0) begin
                lon_dflt_nxt = 1'b0;
                lon_we       = 1'b1;
                lon_wa       = '0;
                lon_len_nxt  = LEN_W'(1);
              end else if (lon_len_r < LEN_W'(LON_CHARS)) begin
                lon_we      = 1'b1;
                lon_len_nxt = lon_len_r + LEN_W'(1);
              end
            end else if (fn_r == gpe_pkg::FIELD_FIX) begin
              if (fc_r == '0) begin
                fix_nxt = (byte_r != gpe_pkg::CH_ZERO);
              end
            end
          end
          if (fc_r < gpe_pkg::COUNT_MAX) begin
            fc_nxt = fc_r + 4'd1;
          end
        end
      end
    end
  end

  // Report reader: latitude characters, then longitude characters.
  assign lat_rd  = lat_dflt_r ? gpe_pkg::lat_dflt_char(int'(sub_r))
                              : lat_text_r[sub_r[LAT_IW-1:0]];
  assign lon_rd  = lon_dflt_r ? gpe_pkg::lon_dflt_char(int'(sub_r))
                              : lon_text_r[sub_r[LON_IW-1:0]];
  assign rd_char = (part_r == gpe_pkg::PART_LON) ? lon_rd : lat_rd;
  assign sub_inc = sub_r + LEN_W'(1);

  assign sts.slot_free = !out_vld_r || out_ready;
  assign sts.at_last   = (part_r == gpe_pkg::PART_LON) && (sub_inc == lon_len_r);

  always_comb begin
    part_nxt    = part_r;
    sub_nxt     = sub_r;
    out_vld_nxt = out_vld_r;
    if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
    if (cmd.rpt_start) begin
      part_nxt = gpe_pkg::PART_LAT;
      sub_nxt  = '0;
    end else if (cmd.rpt_emit) begin
      out_vld_nxt = 1'b1;
      if ((part_r == gpe_pkg::PART_LAT) && (sub_inc == lat_len_r)) begin
        part_nxt = gpe_pkg::PART_LON;
        sub_nxt  = '0;
      end else begin
        sub_nxt = sub_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lp_r       <= '0;
      hm_r       <= 1'b0;
      fn_r       <= 4'd1;
      fc_r       <= '0;
      fix_r      <= 1'b0;
      lat_len_r  <= LEN_W'(gpe_pkg::LAT_DEF_LEN);
      lon_len_r  <= LEN_W'(gpe_pkg::LON_DEF_LEN);
      lat_dflt_r <= 1'b1;
      lon_dflt_r <= 1'b1;
      part_r     <= gpe_pkg::PART_LAT;
      sub_r      <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      lp_r       <= lp_nxt;
      hm_r       <= hm_nxt;
      fn_r       <= fn_nxt;
      fc_r       <= fc_nxt;
      fix_r      <= fix_nxt;
      lat_len_r  <= lat_len_nxt;
      lon_len_r  <= lon_len_nxt;
      lat_dflt_r <= lat_dflt_nxt;
      lon_dflt_r <= lon_dflt_nxt;
      part_r     <= part_nxt;
      sub_r      <= sub_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      byte_r <= rx_byte;
    end
    if (lat_we) begin
      lat_text_r[lat_wa] <= byte_r;
    end
    if (lon_we) begin
      lon_text_r[lon_wa] <= byte_r;
    end
    if (cmd.rpt_emit) begin
      out_part_r <= part_r;
      out_char_r <= rd_char;
      out_fix_r  <= fix_r;
      out_last_r <= sts.at_last;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_part      = out_part_r;
  assign out_char_code = out_char_r;
  assign out_fix_valid = out_fix_r;
  assign out_last      = out_last_r;

endmodule

// File: rtl/core/gpe_checker.sv
// Port-level assertions for the GGA position extractor and their bind statement.
`timescale 1ns / 1ps

module gpe_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_part,
  input logic [7:0] out_char_code,
  input logic       out_fix_valid,
  input logic       out_last
);

  // A stalled result word holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_part) && $stable(out_char_code)
      && $stable(out_fix_valid) && $stable(out_last))
    else $error("stalled result word changed");

  // Every accepted input word closes the input in the cycle after it.
  a_in_pause: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted on consecutive cycles");

  // While a report is still unfinished, no input word is taken.
  a_report_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input ready in the middle of a report");

  // Within one report the fix flag is constant and longitude never returns to latitude.
  a_report_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=>
      !out_valid || ($stable(out_fix_valid) && (out_part || !$past(out_part))))
    else $error("report word out of order");

endmodule

bind gga_position_extractor gpe_checker u_gpe_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_part      (out_ch.part),
  .out_char_code (out_ch.char_code),
  .out_fix_valid (out_ch.fix_valid),
  .out_last      (out_ch.last)
);

// File: tb/sv/gga_report_checker.sv
// Checker that tracks GGA parsing, predicts the report words and compares them on the fly.
`timescale 1ns / 1ps

module gga_report_checker #(
  parameter int unsigned LAT_CHARS = gpe_pkg::LAT_CHARS_DEF,
  parameter int unsigned LON_CHARS = gpe_pkg::LON_CHARS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  gpe_in_if           in_ch,
  gpe_out_if          out_ch,
  output int unsigned mismatches,
  output int unsigned chars_pending
);

  localparam int unsigned LAT_IW = $clog2(LAT_CHARS);
  localparam int unsigned LON_IW = $clog2(LON_CHARS);

  typedef struct packed {
    logic       part;
    logic [7:0] char_code;
    logic       fix_valid;
    logic       last;
  } report_char_t;

  report_char_t report_q[$];

  // Mirror of the parser state.
  logic [2:0] line_pos;
  logic       hdr_match;
  logic [3:0] field_num;
  logic [3:0] field_cnt;
  logic [7:0] lat_text[LAT_CHARS];
  logic [4:0] lat_len;
  logic [7:0] lon_text[LON_CHARS];
  logic [4:0] lon_len;
  logic       fix_flag;

  task automatic clear_line();
    line_pos  = '0;
    hdr_match = 1'b0;
    field_num = 4'd1;
    field_cnt = '0;
  endtask

  task automatic load_lat_default();
    for (int i = 0; i < gpe_pkg::LAT_DEF_LEN; i++) begin
      lat_text[i] = (i == gpe_pkg::LAT_DOT_POS) ? gpe_pkg::CH_DOT : gpe_pkg::CH_ZERO;
    end
    lat_len = 5'(gpe_pkg::LAT_DEF_LEN);
  endtask

  task automatic load_lon_default();
    for (int i = 0; i < gpe_pkg::LON_DEF_LEN; i++) begin
      lon_text[i] = (i == gpe_pkg::LON_DOT_POS) ? gpe_pkg::CH_DOT : gpe_pkg::CH_ZERO;
    end
    lon_len = 5'(gpe_pkg::LON_DEF_LEN);
  endtask

  always @(posedge clk) begin : track
    report_char_t want;
    logic [7:0]   c;
    logic         hdr_ok;
    int unsigned  total;
    int unsigned  n;
    if (!rst_n) begin
      report_q.delete();
      clear_line();
      load_lat_default();
      load_lon_default();
      fix_flag = 1'b0;
    end else begin
      // Results are compared before this edge's input word adds new expectations.
      if (out_ch.valid && out_ch.ready) begin
        if (report_q.size() == 0) begin
          $error("unexpected result word: part %0d char_code 0x%02h", out_ch.part,
                 out_ch.char_code);
          mismatches++;
        end else begin
          want = report_q.pop_front();
          if (out_ch.part !== want.part) begin
            $error("part: expected %0d, actual %0d", want.part, out_ch.part);
            mismatches++;
          end
          if (out_ch.char_code !== want.char_code) begin
            $error("char_code: expected 0x%02h, actual 0x%02h", want.char_code,
                   out_ch.char_code);
            mismatches++;
          end
          if (out_ch.fix_valid !== want.fix_valid) begin
            $error("fix_valid: expected %0d, actual %0d", want.fix_valid, out_ch.fix_valid);
            mismatches++;
          end
          if (out_ch.last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, out_ch.last);
            mismatches++;
          end
        end
      end

      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.action == gpe_pkg::ACT_REPORT) begin
          total = lat_len + lon_len;
          n     = 0;
          for (int i = 0; i < lat_len; i++) begin
            n++;
            want.part      = gpe_pkg::PART_LAT;
            want.char_code = lat_text[i];
            want.fix_valid = fix_flag;
            want.last      = (n == total);
            report_q.push_back(want);
          end
          for (int i = 0; i < lon_len; i++) begin
            n++;
            want.part      = gpe_pkg::PART_LON;
            want.char_code = lon_text[i];
            want.fix_valid = fix_flag;
            want.last      = (n == total);
            report_q.push_back(want);
          end
        end else begin
          c = in_ch.rx_byte;
          if (c == gpe_pkg::CH_NL) begin
            clear_line();
          end else begin
            // Bytes 1 to 5 of the line must spell GPGGA or GNGGA.
            if (line_pos < gpe_pkg::HDR_DONE) begin
              case (line_pos)
                3'd0: hdr_match = 1'b1;
                3'd1, 3'd3, 3'd4: if (c != gpe_pkg::CH_G) hdr_match = 1'b0;
                3'd2: if (c != gpe_pkg::CH_P && c != gpe_pkg::CH_N) hdr_match = 1'b0;
                default: if (c != gpe_pkg::CH_A) hdr_match = 1'b0;
              endcase
              line_pos++;
            end
            hdr_ok = hdr_match && (line_pos >= gpe_pkg::HDR_DONE);

            if (c == gpe_pkg::CH_COMMA) begin
              if (field_num < gpe_pkg::FIELD_MAX) field_num++;
              field_cnt = '0;
              if (hdr_ok) begin
                if (field_num == gpe_pkg::FIELD_LAT) load_lat_default();
                else if (field_num == gpe_pkg::FIELD_LON) load_lon_default();
                else if (field_num == gpe_pkg::FIELD_FIX) fix_flag = 1'b1;
              end
            end else begin
              if (hdr_ok) begin
                if (field_num == gpe_pkg::FIELD_LAT) begin
                  if (field_cnt == 0) lat_len = '0;
                  if (lat_len < LAT_CHARS) begin
                    lat_text[lat_len[LAT_IW-1:0]] = c;
                    lat_len++;
                  end
                end else if (field_num == gpe_pkg::FIELD_LON) begin
                  if (field_cnt == 0) lon_len = '0;
                  if (lon_len < LON_CHARS) begin
                    lon_text[lon_len[LON_IW-1:0]] = c;
                    lon_len++;
                  end
                end else if (field_num == gpe_pkg::FIELD_FIX) begin
                  if (field_cnt == 0) fix_flag = (c != gpe_pkg::CH_ZERO);
                end
              end
              if (field_cnt < gpe_pkg::COUNT_MAX) field_cnt++;
            end
          end
        end
      end
    end
    chars_pending = report_q.size();
  end

endmodule

// File: tb/sv/tb_top.sv
// Top of the GGA position extractor testbench: clock, reset, stimulus, sink stalls, verdict.
`timescale 1ns / 1ps

module tb_top;

  // Rough number of input words to send; the current line is always finished.
  localparam int unsigned IN_WORDS     = 310;
  // Cycles without any accepted word before the run is declared hung.
  localparam int unsigned IDLE_LIMIT   = 1000;
  // Settling time after the last expected result.
  localparam int unsigned DRAIN_CYCLES = 16;

  // Characters used to dress up lines; the parser itself does not care about them.
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_ONE    = 8'h31;

  logic clk;
  logic rst_n;

  gpe_in_if  in_ch ();
  gpe_out_if out_ch ();

  int unsigned mismatches;
  int unsigned chars_pending;
  int unsigned words_sent;
  int unsigned in_gap_max;
  int unsigned out_stall_max;
  int unsigned out_hold;
  int unsigned out_draw;
  int unsigned idle_cycles;

  // Bytes of the line currently being sent.
  logic [7:0] line_q[$];

  // Opening line: an odd first byte (all ones), a matching GPGGA header, an empty
  // time field, a one-character latitude, an empty field 4, a NUL as the whole
  // longitude, an empty field 6 and a fix field of '0'. A report is taken in the
  // middle of field 7 before the newline closes the line.
  logic [7:0] opening_line[$] = '{8'hFF, gpe_pkg::CH_G, gpe_pkg::CH_P, gpe_pkg::CH_G,
                                  gpe_pkg::CH_G, gpe_pkg::CH_A,
                                  gpe_pkg::CH_COMMA, gpe_pkg::CH_COMMA, CH_ONE,
                                  gpe_pkg::CH_COMMA, gpe_pkg::CH_COMMA, 8'h00,
                                  gpe_pkg::CH_COMMA, gpe_pkg::CH_COMMA, gpe_pkg::CH_ZERO};

  gga_position_extractor #(
    .LAT_CHARS(gpe_pkg::LAT_CHARS_DEF),
    .LON_CHARS(gpe_pkg::LON_CHARS_DEF)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  gga_report_checker #(
    .LAT_CHARS(gpe_pkg::LAT_CHARS_DEF),
    .LON_CHARS(gpe_pkg::LON_CHARS_DEF)
  ) u_report_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .mismatches   (mismatches),
    .chars_pending(chars_pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Sends one word. Before it, valid is held low for a random gap; with a zero gap
  // valid simply stays high, so it is never lowered and raised in the same step.
  // The task returns at the edge where the word was accepted.
  task automatic send_word(input logic act, input logic [7:0] data);
    int unsigned gap;
    gap = $urandom_range(in_gap_max, 0);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.action  <= act;
    in_ch.rx_byte <= data;
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
  endtask

  // A report request carries a random byte, which the block must ignore.
  task automatic request_report();
    logic [7:0] junk;
    junk = 8'($urandom_range(255, 0));
    send_word(gpe_pkg::ACT_REPORT, junk);
  endtask

  // Any byte that stays inside its field: everything but a comma or a newline.
  function automatic logic [7:0] rand_text_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255, 0)); while (c == gpe_pkg::CH_COMMA || c == gpe_pkg::CH_NL);
    return c;
  endfunction

  // Field lengths are mostly short; now and then a coordinate runs past its store and,
  // beyond fifteen characters, past the saturating character counter too.
  function automatic int unsigned rand_coord_len();
    if ($urandom_range(3, 0) == 0) return $urandom_range(17, 4);
    return $urandom_range(3, 0);
  endfunction

  // Builds one line. Most lines are well-formed GGA sentences with random contents;
  // the rest have a broken header or are plain noise full of commas and newlines.
  task automatic build_line();
    int unsigned kind;
    int unsigned nf;
    int unsigned len;
    int unsigned bad_pos;
    logic [7:0]  c;
    line_q.delete();
    kind = $urandom_range(9, 0);

    if (kind == 9) begin
      len = $urandom_range(20, 0);
      repeat (len) begin
        case ($urandom_range(3, 0))
          0:       c = gpe_pkg::CH_COMMA;
          1:       c = gpe_pkg::CH_NL;
          default: c = 8'($urandom_range(255, 0));
        endcase
        line_q.push_back(c);
      end
      return;
    end

    // Byte 0 is normally the dollar sign, but the parser accepts any first byte.
    if ($urandom_range(3, 0) == 0) line_q.push_back(rand_text_char());
    else line_q.push_back(CH_DOLLAR);
    line_q.push_back(gpe_pkg::CH_G);
    line_q.push_back($urandom_range(1, 0) ? gpe_pkg::CH_P : gpe_pkg::CH_N);
    line_q.push_back(gpe_pkg::CH_G);
    line_q.push_back(gpe_pkg::CH_G);
    line_q.push_back(gpe_pkg::CH_A);

    // A broken header: one of bytes 1 to 5 replaced by a byte that never matches.
    if (kind == 8) begin
      bad_pos = $urandom_range(5, 1);
      do c = rand_text_char();
      while (c == gpe_pkg::CH_G || c == gpe_pkg::CH_P || c == gpe_pkg::CH_N ||
             c == gpe_pkg::CH_A);
      line_q[bad_pos] = c;
    end

    // Number of the last field; long lines push the field number into saturation.
    if ($urandom_range(4, 0) == 0) nf = $urandom_range(18, 9);
    else nf = $urandom_range(8, 2);

    for (int f = 2; f <= nf; f++) begin
      line_q.push_back(gpe_pkg::CH_COMMA);
      if (f == gpe_pkg::FIELD_LAT || f == gpe_pkg::FIELD_LON) begin
        len = rand_coord_len();
      end else if (f == gpe_pkg::FIELD_FIX) begin
        // The fix field is empty, a '0' or something else, maybe with a tail.
        case ($urandom_range(2, 0))
          0: len = 0;
          1: begin
            line_q.push_back(gpe_pkg::CH_ZERO);
            len = $urandom_range(1, 0);
          end
          default: len = $urandom_range(2, 1);
        endcase
      end else begin
        len = $urandom_range(1, 0);
      end
      repeat (len) line_q.push_back(rand_text_char());
    end

    // Checksum tail and carriage return; both are ordinary characters to the block.
    if ($urandom_range(1, 0)) begin
      line_q.push_back(CH_STAR);
      line_q.push_back(rand_text_char());
      line_q.push_back(rand_text_char());
      line_q.push_back(CH_CR);
    end
    // A missing newline lets the next line run on into this one.
    if ($urandom_range(7, 0) != 0) line_q.push_back(gpe_pkg::CH_NL);
  endtask

  // Result sink: before each word it holds ready low for a random number of cycles,
  // then keeps ready high until the word is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_hold     <= 0;
    end else if (out_hold != 0) begin
      out_hold <= out_hold - 1;
      if (out_hold == 1) out_ch.ready <= 1'b1;
    end else if (!out_ch.ready || out_ch.valid) begin
      out_draw = $urandom_range(out_stall_max, 0);
      if (out_draw == 0) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b0;
        out_hold     <= out_draw;
      end
    end
  end

  // Watchdog: any accepted word on either channel restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL gga_position_extractor");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    in_ch.valid   <= 1'b0;
    in_ch.action  <= gpe_pkg::ACT_BYTE;
    in_ch.rx_byte <= 8'h00;
    rst_n         <= 1'b0;
    out_stall_max <= 0;
    in_gap_max  = 0;
    words_sent  = 0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. A report straight after reset shows both default texts with the
    // fix flag clear; the opening line then replaces both stores with one character
    // each, which gives the shortest possible report, taken in the middle of a line.
    request_report();
    foreach (opening_line[i]) send_word(gpe_pkg::ACT_BYTE, opening_line[i]);
    send_word(gpe_pkg::ACT_REPORT, 8'h00);
    send_word(gpe_pkg::ACT_BYTE, gpe_pkg::CH_NL);
    send_word(gpe_pkg::ACT_REPORT, 8'hFF);

    // Random part, one line at a time. Each line picks its own idling pattern so that
    // stretches without any gaps alternate with stalls on either or both sides.
    while (words_sent < IN_WORDS) begin
      case ($urandom_range(3, 0))
        0: begin
          in_gap_max     = 0;
          out_stall_max <= 0;
        end
        1: begin
          in_gap_max     = 8;
          out_stall_max <= 0;
        end
        2: begin
          in_gap_max     = 0;
          out_stall_max <= 8;
        end
        default: begin
          in_gap_max     = 8;
          out_stall_max <= 8;
        end
      endcase
      build_line();
      foreach (line_q[i]) begin
        send_word(gpe_pkg::ACT_BYTE, line_q[i]);
        // Occasional reports mid-line catch partially received fields.
        if ($urandom_range(11, 0) == 0) request_report();
      end
      request_report();
    end
    in_ch.valid <= 1'b0;

    // The checker sees the last accepted word at the edge just passed; one more edge
    // makes sure its expectations are counted before waiting for them to drain.
    @(posedge clk);
    wait (chars_pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && chars_pending == 0) begin
      $display("PASS gga_position_extractor");
    end else begin
      $display("FAIL gga_position_extractor");
    end
    $finish;
  end

endmodule
